// ===== rtl/particle_box_boundary_response_unit_defines.svh =====
// ----------------------------------------------------------------------------
// particle box boundary response: assertion macros
// shared concurrent assertion forms for the boundary response rtl
// ----------------------------------------------------------------------------
`ifndef PARTICLE_BOX_BOUNDARY_RESPONSE_UNIT_DEFINES_SVH
`define PARTICLE_BOX_BOUNDARY_RESPONSE_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PBBR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define PBBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pbbr_pkg.sv =====
// ----------------------------------------------------------------------------
// pbbr_pkg
// types, constants and arithmetic helpers for the box boundary response unit
// ----------------------------------------------------------------------------
package pbbr_pkg;

	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned FRAC_BITS = 20;

	// coefficients in unsigned q0.15
	localparam int unsigned COEF_BITS = 15;
	localparam logic [COEF_BITS-1:0] COEF_BOUNCE     = COEF_BITS'(9830);
	localparam logic [COEF_BITS-1:0] COEF_WALL_FRIC  = COEF_BITS'(26214);
	localparam logic [COEF_BITS-1:0] COEF_FLOOR_FRIC = COEF_BITS'(30147);
	localparam logic [COEF_BITS-1:0] COEF_HALF = {1'b1, {(COEF_BITS-1){1'b0}}};

	// speed threshold 0.1, fits below 2^(FRAC_BITS-3)
	localparam int unsigned SLOW_BITS = FRAC_BITS - 3;
	localparam int unsigned SQ_BITS   = 2 * SLOW_BITS;
	localparam int unsigned SUM_BITS  = SQ_BITS + 2;
	localparam logic [SLOW_BITS-1:0] SLOW_LIMIT =
		SLOW_BITS'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [SQ_BITS-1:0] SLOW_SQ =
		SQ_BITS'(64'(SLOW_LIMIT) * 64'(SLOW_LIMIT));

	// reset values: walls at +-20.0, margin 0.075
	localparam logic [WORD_BITS-1:0] WALL_RESET_POS = WORD_BITS'(64'd20 << FRAC_BITS);
	localparam logic [WORD_BITS-1:0] WALL_RESET_NEG = WORD_BITS'(-(64'sd20 <<< FRAC_BITS));
	localparam logic [WORD_BITS-2:0] MARGIN_RESET =
		(WORD_BITS-1)'(((64'd75 << FRAC_BITS) + 64'd500) / 64'd1000);

	// wall cells in the chain, and pipeline depth from accept to result
	localparam int unsigned NUM_WALLS = 6;
	localparam int unsigned LATENCY   = 1 + 2 * NUM_WALLS + 3;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [WORD_BITS:0]   wide_t;
	typedef logic [2:0][WORD_BITS-1:0]   vec3_t;

	typedef struct packed {
		vec3_t pos;
		vec3_t vel;
		logic  last;
	} particle_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	// static description of one wall cell
	typedef struct packed {
		word_t wall;
		axis_t axis;
		logic  lower;
		logic  is_floor;
	} wall_sel_t;

	typedef enum logic [2:0] {
		REG_BOX_MIN_X    = 3'd0,
		REG_BOX_MAX_X    = 3'd1,
		REG_BOX_MIN_Y    = 3'd2,
		REG_BOX_MAX_Y    = 3'd3,
		REG_BOX_MIN_Z    = 3'd4,
		REG_BOX_MAX_Z    = 3'd5,
		REG_WALL_MARGIN  = 3'd6,
		REG_GRAVITY_STEP = 3'd7
	} reg_idx_t;

	function automatic word_t sat_word(input wide_t x);
		word_t r;
		if (x[WORD_BITS] != x[WORD_BITS-1]) begin
			r = x[WORD_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
		end else begin
			r = x[WORD_BITS-1:0];
		end
		return r;
	endfunction

	function automatic logic [WORD_BITS-1:0] mag_word(input word_t v);
		logic [WORD_BITS-1:0] m;
		m = v[WORD_BITS-1] ? (~v + 1'b1) : v;
		return m;
	endfunction

	function automatic word_t with_sign(input logic [WORD_BITS-1:0] m, input logic neg);
		word_t r;
		r = neg ? (~m + 1'b1) : m;
		return r;
	endfunction

	// round to nearest of m * c / 2^15
	function automatic logic [WORD_BITS-1:0] scale_mag(input logic [WORD_BITS-1:0] m,
			input logic [COEF_BITS-1:0] c);
		logic [WORD_BITS+COEF_BITS-1:0] prod;
		prod = (WORD_BITS+COEF_BITS)'(m) * (WORD_BITS+COEF_BITS)'(c)
			+ (WORD_BITS+COEF_BITS)'(COEF_HALF);
		return prod[WORD_BITS+COEF_BITS-1:COEF_BITS];
	endfunction

	function automatic logic [1:0] axis_index(input axis_t a);
		logic [1:0] n;
		case (a)
			AXIS_X:  n = 2'd0;
			AXIS_Y:  n = 2'd1;
			AXIS_Z:  n = 2'd2;
			default: n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/particle_box_boundary_response_unit.sv =====
// ----------------------------------------------------------------------------
// particle_box_boundary_response_unit
// gravity step, six wall cells in a chain, slow particle halving
// throughput: one particle per cycle, busy is never raised
// the chain has one gravity stage, two stages per wall cell and three speed stages
// reset clears all valid bits and loads the default box, margin and gravity
// ----------------------------------------------------------------------------
`include "particle_box_boundary_response_unit_defines.svh"

module particle_box_boundary_response_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [pbbr_pkg::WORD_BITS-1:0] cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  logic [pbbr_pkg::WORD_BITS-1:0] pos_x,
	input  logic [pbbr_pkg::WORD_BITS-1:0] pos_y,
	input  logic [pbbr_pkg::WORD_BITS-1:0] pos_z,
	input  logic [pbbr_pkg::WORD_BITS-1:0] vel_x,
	input  logic [pbbr_pkg::WORD_BITS-1:0] vel_y,
	input  logic [pbbr_pkg::WORD_BITS-1:0] vel_z,
	input  logic                          last_in_frame,
	output logic                          done,
	output logic [pbbr_pkg::WORD_BITS-1:0] new_pos_x,
	output logic [pbbr_pkg::WORD_BITS-1:0] new_pos_y,
	output logic [pbbr_pkg::WORD_BITS-1:0] new_pos_z,
	output logic [pbbr_pkg::WORD_BITS-1:0] new_vel_x,
	output logic [pbbr_pkg::WORD_BITS-1:0] new_vel_y,
	output logic [pbbr_pkg::WORD_BITS-1:0] new_vel_z,
	output logic                          frame_done
);

	pbbr_pkg::word_t                box_min_x_q;
	pbbr_pkg::word_t                box_max_x_q;
	pbbr_pkg::word_t                box_min_y_q;
	pbbr_pkg::word_t                box_max_y_q;
	pbbr_pkg::word_t                box_min_z_q;
	pbbr_pkg::word_t                box_max_z_q;
	logic [pbbr_pkg::WORD_BITS-2:0] wall_margin_q;
	pbbr_pkg::word_t                gravity_step_q;

	logic                           accept;
	pbbr_pkg::word_t                vy_in;
	pbbr_pkg::wide_t                vy_sum;
	pbbr_pkg::particle_t            grav_part;
	logic                           in_valid_s1;
	pbbr_pkg::particle_t            in_part_s1;

	pbbr_pkg::wall_sel_t            sel [pbbr_pkg::NUM_WALLS];
	logic                           chain_valid [pbbr_pkg::NUM_WALLS+1];
	pbbr_pkg::particle_t            chain_part  [pbbr_pkg::NUM_WALLS+1];
	logic                           res_valid;
	pbbr_pkg::particle_t            res_part;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_min_x_q    <= pbbr_pkg::WALL_RESET_NEG;
			box_max_x_q    <= pbbr_pkg::WALL_RESET_POS;
			box_min_y_q    <= pbbr_pkg::WALL_RESET_NEG;
			box_max_y_q    <= pbbr_pkg::WALL_RESET_POS;
			box_min_z_q    <= pbbr_pkg::WALL_RESET_NEG;
			box_max_z_q    <= pbbr_pkg::WALL_RESET_POS;
			wall_margin_q  <= pbbr_pkg::MARGIN_RESET;
			gravity_step_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (pbbr_pkg::reg_idx_t'(cfg_index))
				pbbr_pkg::REG_BOX_MIN_X:    box_min_x_q    <= cfg_data;
				pbbr_pkg::REG_BOX_MAX_X:    box_max_x_q    <= cfg_data;
				pbbr_pkg::REG_BOX_MIN_Y:    box_min_y_q    <= cfg_data;
				pbbr_pkg::REG_BOX_MAX_Y:    box_max_y_q    <= cfg_data;
				pbbr_pkg::REG_BOX_MIN_Z:    box_min_z_q    <= cfg_data;
				pbbr_pkg::REG_BOX_MAX_Z:    box_max_z_q    <= cfg_data;
				pbbr_pkg::REG_WALL_MARGIN:  wall_margin_q  <= cfg_data[pbbr_pkg::WORD_BITS-2:0];
				pbbr_pkg::REG_GRAVITY_STEP: gravity_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// gravity on the vertical velocity, saturated
	always_comb begin
		vy_in  = vel_y;
		vy_sum = {vy_in[pbbr_pkg::WORD_BITS-1], vy_in}
			+ {gravity_step_q[pbbr_pkg::WORD_BITS-1], gravity_step_q};
		grav_part.pos[0] = pos_x;
		grav_part.pos[1] = pos_y;
		grav_part.pos[2] = pos_z;
		grav_part.vel[0] = vel_x;
		grav_part.vel[1] = pbbr_pkg::sat_word(vy_sum);
		grav_part.vel[2] = vel_z;
		grav_part.last   = last_in_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else begin
			in_valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		in_part_s1 <= grav_part;
	end

	// wall order: x-min, x-max, y-min (floor), y-max, z-min, z-max
	always_comb begin
		sel[0] = '{wall: box_min_x_q, axis: pbbr_pkg::AXIS_X, lower: 1'b1, is_floor: 1'b0};
		sel[1] = '{wall: box_max_x_q, axis: pbbr_pkg::AXIS_X, lower: 1'b0, is_floor: 1'b0};
		sel[2] = '{wall: box_min_y_q, axis: pbbr_pkg::AXIS_Y, lower: 1'b1, is_floor: 1'b1};
		sel[3] = '{wall: box_max_y_q, axis: pbbr_pkg::AXIS_Y, lower: 1'b0, is_floor: 1'b0};
		sel[4] = '{wall: box_min_z_q, axis: pbbr_pkg::AXIS_Z, lower: 1'b1, is_floor: 1'b0};
		sel[5] = '{wall: box_max_z_q, axis: pbbr_pkg::AXIS_Z, lower: 1'b0, is_floor: 1'b0};
	end

	assign chain_valid[0] = in_valid_s1;
	assign chain_part[0]  = in_part_s1;

	for (genvar i = 0; i < pbbr_pkg::NUM_WALLS; i++) begin : g_wall
		pbbr_wall_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.sel       (sel[i]),
			.margin    (wall_margin_q),
			.in_valid  (chain_valid[i]),
			.in_part   (chain_part[i]),
			.out_valid (chain_valid[i+1]),
			.out_part  (chain_part[i+1])
		);
	end

	pbbr_speed_stage u_speed (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[pbbr_pkg::NUM_WALLS]),
		.in_part   (chain_part[pbbr_pkg::NUM_WALLS]),
		.out_valid (res_valid),
		.out_part  (res_part)
	);

	assign done       = res_valid;
	assign new_pos_x  = res_part.pos[0];
	assign new_pos_y  = res_part.pos[1];
	assign new_pos_z  = res_part.pos[2];
	assign new_vel_x  = res_part.vel[0];
	assign new_vel_y  = res_part.vel[1];
	assign new_vel_z  = res_part.vel[2];
	assign frame_done = res_part.last;

	`PBBR_ASSERT_SAME(a_done_latency, clk, arst_n, done,
		$past(accept, pbbr_pkg::LATENCY), "result without a matching accepted transaction")

endmodule

// ===== rtl/pbbr_wall_cell.sv =====
// ----------------------------------------------------------------------------
// pbbr_wall_cell
// one wall of the box: clamp, bounce or floor settle, two register stages
// ----------------------------------------------------------------------------
`include "particle_box_boundary_response_unit_defines.svh"

module pbbr_wall_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pbbr_pkg::wall_sel_t  sel,
	input  logic [pbbr_pkg::WORD_BITS-2:0] margin,
	input  logic                 in_valid,
	input  pbbr_pkg::particle_t  in_part,
	output logic                 out_valid,
	output pbbr_pkg::particle_t  out_part
);

	logic [1:0]            n;
	pbbr_pkg::word_t       p_n;
	pbbr_pkg::word_t       v_n;
	pbbr_pkg::wide_t       wall_ext;
	pbbr_pkg::wide_t       marg_ext;
	pbbr_pkg::wide_t       lim;
	pbbr_pkg::wide_t       p_ext;
	logic                  over;
	logic                  outward;
	logic                  settle;
	logic [2:0][pbbr_pkg::WORD_BITS-1:0] mags;
	pbbr_pkg::particle_t   clamp_part;

	logic                  valid_s1;
	pbbr_pkg::particle_t   part_s1;
	logic [2:0][pbbr_pkg::WORD_BITS-1:0] mag_s1;
	logic                  hit_s1;
	logic                  settle_s1;

	pbbr_pkg::particle_t   next_part;
	logic                  out_valid_q;
	pbbr_pkg::particle_t   out_part_q;

	always_comb begin
		n        = pbbr_pkg::axis_index(sel.axis);
		p_n      = in_part.pos[n];
		v_n      = in_part.vel[n];
		wall_ext = {sel.wall[pbbr_pkg::WORD_BITS-1], sel.wall};
		marg_ext = {2'b00, margin};
		p_ext    = {p_n[pbbr_pkg::WORD_BITS-1], p_n};
		lim      = sel.lower ? (wall_ext + marg_ext) : (wall_ext - marg_ext);
		over     = sel.lower ? (p_ext < lim) : (p_ext > lim);
		outward  = sel.lower ? v_n[pbbr_pkg::WORD_BITS-1]
			: (!v_n[pbbr_pkg::WORD_BITS-1] && (v_n != '0));
		for (int k = 0; k < 3; k++) begin
			mags[k] = pbbr_pkg::mag_word(in_part.vel[k]);
		end
		settle = sel.is_floor && sel.lower
			&& (mags[n] < pbbr_pkg::WORD_BITS'(pbbr_pkg::SLOW_LIMIT));
		clamp_part = in_part;
		if (over) begin
			clamp_part.pos[n] = pbbr_pkg::sat_word(lim);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= in_valid;
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		part_s1   <= clamp_part;
		mag_s1    <= mags;
		hit_s1    <= over && outward;
		settle_s1 <= settle;
	end

	// on a hit the normal component reflects, or is zeroed when settling, tangential ones take friction
	always_comb begin
		logic [pbbr_pkg::COEF_BITS-1:0] coef;
		logic [pbbr_pkg::WORD_BITS-1:0] scaled;
		logic                           neg;
		next_part = part_s1;
		for (int k = 0; k < 3; k++) begin
			if (k == n) begin
				coef = pbbr_pkg::COEF_BOUNCE;
			end else begin
				coef = settle_s1 ? pbbr_pkg::COEF_FLOOR_FRIC : pbbr_pkg::COEF_WALL_FRIC;
			end
			scaled = pbbr_pkg::scale_mag(mag_s1[k], coef);
			neg    = part_s1.vel[k][pbbr_pkg::WORD_BITS-1] ^ (k == n);
			if (hit_s1) begin
				if ((k == n) && settle_s1) begin
					next_part.vel[k] = '0;
				end else begin
					next_part.vel[k] = pbbr_pkg::with_sign(scaled, neg);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		out_part_q <= next_part;
	end

	assign out_valid = out_valid_q;
	assign out_part  = out_part_q;

	`PBBR_ASSERT_NEXT(a_settle_zero, clk, arst_n, valid_s1 && hit_s1 && settle_s1,
		out_part_q.vel[n] == '0, "floor settle left a normal velocity")
	`PBBR_ASSERT_NEXT(a_lower_inward, clk, arst_n, valid_s1 && hit_s1 && sel.lower,
		!out_part_q.vel[n][pbbr_pkg::WORD_BITS-1], "lower wall left particle moving out")

endmodule

// ===== rtl/pbbr_speed_stage.sv =====
// ----------------------------------------------------------------------------
// pbbr_speed_stage
// slow particle test and velocity halving, ends in the result register
// ----------------------------------------------------------------------------
`include "particle_box_boundary_response_unit_defines.svh"

module pbbr_speed_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  pbbr_pkg::particle_t in_part,
	output logic                out_valid,
	output pbbr_pkg::particle_t out_part
);

	logic [2:0][pbbr_pkg::WORD_BITS-1:0] mags;
	logic                                under_lim;

	logic                                valid_s1;
	pbbr_pkg::particle_t                 part_s1;
	logic [2:0][pbbr_pkg::WORD_BITS-1:0] mag_s1;
	logic                                under_lim_s1;

	logic [2:0][pbbr_pkg::SQ_BITS-1:0]   sq;
	pbbr_pkg::vec3_t                     half;

	logic                                valid_s2;
	pbbr_pkg::particle_t                 part_s2;
	logic [2:0][pbbr_pkg::SQ_BITS-1:0]   sq_s2;
	pbbr_pkg::vec3_t                     half_s2;
	logic                                under_lim_s2;

	logic [pbbr_pkg::SUM_BITS-1:0]       sum_sq;
	logic                                slow;
	logic                                out_valid_q;
	pbbr_pkg::particle_t                 out_part_q;

	always_comb begin
		under_lim = 1'b1;
		for (int k = 0; k < 3; k++) begin
			mags[k] = pbbr_pkg::mag_word(in_part.vel[k]);
			if (mags[k] >= pbbr_pkg::WORD_BITS'(pbbr_pkg::SLOW_LIMIT)) begin
				under_lim = 1'b0;
			end
		end
	end

	// squares only matter when every component is under the threshold
	always_comb begin
		logic [pbbr_pkg::WORD_BITS:0] rounded;
		for (int k = 0; k < 3; k++) begin
			sq[k] = pbbr_pkg::SQ_BITS'(mag_s1[k][pbbr_pkg::SLOW_BITS-1:0])
				* pbbr_pkg::SQ_BITS'(mag_s1[k][pbbr_pkg::SLOW_BITS-1:0]);
			rounded = {1'b0, mag_s1[k]} + 1'b1;
			half[k] = pbbr_pkg::with_sign(rounded[pbbr_pkg::WORD_BITS:1],
				part_s1.vel[k][pbbr_pkg::WORD_BITS-1]);
		end
	end

	always_comb begin
		sum_sq = pbbr_pkg::SUM_BITS'(sq_s2[0]) + pbbr_pkg::SUM_BITS'(sq_s2[1])
			+ pbbr_pkg::SUM_BITS'(sq_s2[2]);
		slow   = under_lim_s2 && (sum_sq < pbbr_pkg::SUM_BITS'(pbbr_pkg::SLOW_SQ));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		part_s1  <= in_part;
		mag_s1   <= mags;
		under_lim_s1 <= under_lim;
		part_s2  <= part_s1;
		sq_s2    <= sq;
		half_s2  <= half;
		under_lim_s2 <= under_lim_s1;
		out_part_q.pos  <= part_s2.pos;
		out_part_q.last <= part_s2.last;
		out_part_q.vel  <= slow ? half_s2 : part_s2.vel;
	end

	assign out_valid = out_valid_q;
	assign out_part  = out_part_q;

	`PBBR_ASSERT_NEXT(a_fast_passes, clk, arst_n, valid_s2 && !under_lim_s2,
		out_part_q.vel == $past(part_s2.vel), "fast particle velocity was altered")

endmodule
